// File: hw/rtl/per_pixel_mean_sigma_stack_top_macros.svh
// Assertion helpers for the top module, which checks its own logic.
`ifndef PER_PIXEL_MEAN_SIGMA_STACK_TOP_MACROS_SVH
`define PER_PIXEL_MEAN_SIGMA_STACK_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPMS_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppms check failed");

// The consequent must hold in the cycle after the antecedent.
`define PPMS_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppms check failed");

`endif

// File: hw/rtl/ppms_pkg.sv
`default_nettype none
package ppms_pkg;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FRAME_COUNT  = 2'd2;

    localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd1024;
    localparam logic [8:0]  RST_FRAME_COUNT  = 9'd2;

    // Queue depths: the result queue must cover the whole back pipeline.
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 32;

    // Quotient bits of both dividers and steps of the square root.
    localparam int DIV_BITS  = 16;
    localparam int ROOT_STEPS = 8;

    typedef struct packed {
        logic first;
        logic last_frame;
        logic last_pixel;
    } flags_t;

endpackage
`default_nettype wire

// File: hw/rtl/per_pixel_mean_sigma_stack_top.sv
// Channel     Handshake                  Payload
// pixels in   push / full                pixel
// results     pop / empty                mean_value, sigma_value, last_pixel
// config      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One pixel is accepted per cycle while the input queue is not full; the store is read, updated and written back
// in one pass, with the previous write forwarded when it hits the same address.
// A pixel that leaves the input queue passes through the store update, two 16-step
// dividers and an 8-step square root in a straight pipeline to its result request.
// Reset clears counters, queues and pipeline valids; the sum stores hold garbage
// until the first frame of a stack writes them. Pixels stall only when the
// result queue, counting requests still in flight, has no room left.
`default_nettype none
`include "per_pixel_mean_sigma_stack_top_macros.svh"
module per_pixel_mean_sigma_stack_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_FRAMES = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  pixel,
    output logic             empty,
    input  wire logic        pop,
    output logic      [7:0]  mean_value,
    output logic      [7:0]  sigma_value,
    output logic             last_pixel,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int N_W    = $clog2(MAX_FRAMES + 1);
    localparam int FL_W   = $bits(ppms_pkg::flags_t);
    localparam int MID_W  = ADDR_W + 8 + FL_W;
    localparam int RES_W  = 17;
    localparam int RV_W   = $clog2(ppms_pkg::OUT_DEPTH + 1);

    // Configuration registers. Any write restarts the stack counters.
    logic [10:0] image_width_reg;
    logic [10:0] image_height_reg;
    logic [8:0]  frame_count_reg;
    logic        cfg_write;
    logic [1:0]  cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= ppms_pkg::RST_IMAGE_WIDTH;
            image_height_reg <= ppms_pkg::RST_IMAGE_HEIGHT;
            frame_count_reg  <= ppms_pkg::RST_FRAME_COUNT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ppms_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[10:0];
                ppms_pkg::REG_IMAGE_HEIGHT: image_height_reg <= pwdata[10:0];
                ppms_pkg::REG_FRAME_COUNT:  frame_count_reg  <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            ppms_pkg::REG_IMAGE_WIDTH:  prdata = 32'(image_width_reg);
            ppms_pkg::REG_IMAGE_HEIGHT: prdata = 32'(image_height_reg);
            ppms_pkg::REG_FRAME_COUNT:  prdata = 32'(frame_count_reg);
            default:                    prdata = '0;
        endcase
    end

    // Front end: position counters classify each pixel on its way in.
    logic                  in_accept;
    logic                  mid_full;
    logic                  mid_empty;
    logic [ADDR_W-1:0]     front_addr;
    ppms_pkg::flags_t      front_flags;
    logic [N_W-1:0]        n_eff;
    logic [MID_W-1:0]      mid_rdata;

    assign full      = mid_full;
    assign in_accept = push && !mid_full;

    ppms_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_FRAMES (MAX_FRAMES),
        .ADDR_W     (ADDR_W),
        .N_W        (N_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .restart      (cfg_write),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .frame_count  (frame_count_reg),
        .addr         (front_addr),
        .flags        (front_flags),
        .n_eff        (n_eff)
    );

    // Short queue that lets the front keep taking pixels while the back waits.
    logic issue;

    ppms_fifo #(
        .WIDTH (MID_W),
        .DEPTH (ppms_pkg::MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (in_accept),
        .wdata ({front_addr, pixel, front_flags}),
        .pop   (issue),
        .rdata (mid_rdata),
        .empty (mid_empty),
        .full  (mid_full)
    );

    // Every issued pixel holds a result slot until it retires without a result
    // or its result request is popped, so the back pipeline never has to stall.
    logic [RV_W-1:0] reserved_reg;
    logic [RV_W-1:0] reserved_next;
    logic            retire;
    logic            res_valid;
    logic [7:0]      res_mean;
    logic [7:0]      res_sigma;
    logic            res_last;
    logic            out_full;
    logic            out_pop;
    logic [RES_W-1:0] out_rdata;

    assign issue   = !mid_empty && (reserved_reg < RV_W'(ppms_pkg::OUT_DEPTH));
    assign out_pop = pop && !empty;

    always_comb
    begin
        reserved_next = reserved_reg + RV_W'(issue) - RV_W'(retire) - RV_W'(out_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg <= '0;
        end
        else
        begin
            reserved_reg <= reserved_next;
        end
    end

    ppms_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_FRAMES (MAX_FRAMES),
        .ADDR_W     (ADDR_W),
        .N_W        (N_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (issue),
        .in_addr   (mid_rdata[MID_W-1:8+FL_W]),
        .in_pixel  (mid_rdata[8+FL_W-1:FL_W]),
        .in_flags  (mid_rdata[FL_W-1:0]),
        .n_eff     (n_eff),
        .retire    (retire),
        .out_valid (res_valid),
        .out_mean  (res_mean),
        .out_sigma (res_sigma),
        .out_last  (res_last)
    );

    // Result queue presented to the consumer.
    ppms_fifo #(
        .WIDTH (RES_W),
        .DEPTH (ppms_pkg::OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_valid),
        .wdata ({res_mean, res_sigma, res_last}),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty),
        .full  (out_full)
    );

    assign mean_value  = out_rdata[16:9];
    assign sigma_value = out_rdata[8:1];
    assign last_pixel  = out_rdata[0];

    `PPMS_CHECK(a_slots_bounded, 1'b1, reserved_reg <= RV_W'(ppms_pkg::OUT_DEPTH))
    `PPMS_CHECK(a_no_result_overflow, res_valid, !out_full)
    `PPMS_CHECK(a_no_double_retire, res_valid, reserved_reg != RV_W'(0))
    `PPMS_CHECK_NEXT(a_issue_takes_slot, issue && !retire && !out_pop,
                     reserved_reg == $past(reserved_reg) + RV_W'(1))

endmodule
`default_nettype wire

// File: hw/rtl/ppms_ram.sv
`default_nettype none
module ppms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/ppms_fifo.sv
`default_nettype none
module ppms_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty,
    output logic                  full
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [0:DEPTH-1];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == CW'(0));
    assign full    = (count_reg == CW'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/ppms_front.sv
`default_nettype none
module ppms_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_FRAMES = 256,
    parameter int ADDR_W     = 20,
    parameter int N_W        = 9
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic               restart,
    input  wire logic [10:0]        image_width,
    input  wire logic [10:0]        image_height,
    input  wire logic [8:0]         frame_count,
    output logic      [ADDR_W-1:0]  addr,
    output ppms_pkg::flags_t        flags,
    output logic      [N_W-1:0]     n_eff
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    logic [XW-1:0] col_reg;
    logic [YW-1:0] row_reg;
    logic [FW-1:0] frame_reg;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic          last_col;
    logic          last_row;
    logic          last_frame;

    // Out-of-range settings saturate into 1..maximum.
    always_comb
    begin
        if (image_width == 11'd0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(image_width) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(image_width);
        end
        if (image_height == 11'd0)
        begin
            h_eff = HW'(1);
        end
        else if (32'(image_height) > MAX_HEIGHT)
        begin
            h_eff = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HW'(image_height);
        end
        if (frame_count == 9'd0)
        begin
            n_eff = N_W'(1);
        end
        else if (32'(frame_count) > MAX_FRAMES)
        begin
            n_eff = N_W'(MAX_FRAMES);
        end
        else
        begin
            n_eff = N_W'(frame_count);
        end
    end

    assign last_col   = (WW'(col_reg) == (w_eff - WW'(1)));
    assign last_row   = (HW'(row_reg) == (h_eff - HW'(1)));
    assign last_frame = (N_W'(frame_reg) == (n_eff - N_W'(1)));

    assign addr = ADDR_W'(row_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_reg);
    assign flags.first      = (frame_reg == FW'(0));
    assign flags.last_frame = last_frame;
    assign flags.last_pixel = last_col && last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            frame_reg <= '0;
        end
        else if (restart)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            frame_reg <= '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                if (last_row)
                begin
                    row_reg   <= '0;
                    frame_reg <= last_frame ? FW'(0) : frame_reg + FW'(1);
                end
                else
                begin
                    row_reg <= row_reg + YW'(1);
                end
            end
            else
            begin
                col_reg <= col_reg + XW'(1);
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/ppms_back.sv
`default_nettype none
module ppms_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_FRAMES = 256,
    parameter int ADDR_W     = 20,
    parameter int N_W        = 9
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [ADDR_W-1:0] in_addr,
    input  wire logic [7:0]        in_pixel,
    input  wire ppms_pkg::flags_t  in_flags,
    input  wire logic [N_W-1:0]    n_eff,
    output logic                   retire,
    output logic                   out_valid,
    output logic      [7:0]        out_mean,
    output logic      [7:0]        out_sigma,
    output logic                   out_last
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int SUM_W  = $clog2(255 * MAX_FRAMES + 1);
    localparam int SQ_W   = $clog2(65025 * MAX_FRAMES + 1);
    localparam int NUM_W  = N_W + SQ_W;
    localparam int SS_W   = 2 * SUM_W;
    localparam int DEN_W  = 2 * N_W;
    localparam int QW     = ppms_pkg::DIV_BITS;
    localparam int RS     = ppms_pkg::ROOT_STEPS;
    localparam int CW     = NUM_W + DEN_W + QW;
    localparam int MW     = SUM_W + N_W + QW;

    // Stage A: store read data arrives, sums are updated and written back.
    logic                  a_valid_reg;
    logic [ADDR_W-1:0]     a_addr_reg;
    logic [7:0]            a_pix_reg;
    ppms_pkg::flags_t      a_flags_reg;
    logic [SUM_W+SQ_W-1:0] ram_rdata;
    logic [SUM_W-1:0]      old_sum;
    logic [SQ_W-1:0]       old_sq;
    logic [SUM_W-1:0]      new_sum;
    logic [SQ_W-1:0]       new_sq;
    logic [15:0]           pix_sq;

    // The previous write lands on the same edge as this item's read.
    logic                  fw_valid_reg;
    logic [ADDR_W-1:0]     fw_addr_reg;
    logic [SUM_W-1:0]      fw_sum_reg;
    logic [SQ_W-1:0]       fw_sq_reg;

    logic                  b_ok_reg;
    logic [SUM_W-1:0]      b_sum_reg;
    logic [SQ_W-1:0]       b_sq_reg;
    logic                  b_last_reg;

    logic                  c_ok_reg;
    logic [NUM_W-1:0]      c_num_reg;
    logic [SS_W-1:0]       c_ss_reg;
    logic [SUM_W-1:0]      c_sum_reg;
    logic                  c_last_reg;
    logic [DEN_W-1:0]      den_reg;

    logic                  dv_reg [0:QW];
    logic                  dl_reg [0:QW];
    logic [CW-1:0]         vr_reg [0:QW];
    logic [QW-1:0]         vq_reg [0:QW];
    logic [MW-1:0]         mr_reg [0:QW];
    logic [QW-1:0]         mq_reg [0:QW];

    logic                  rt_ok_reg   [1:RS];
    logic                  rt_last_reg [1:RS];
    logic [15:0]           rt_v_reg    [1:RS];
    logic [15:0]           rt_r_reg    [1:RS];
    logic [7:0]            rt_m_reg    [1:RS];

    ppms_ram #(
        .WIDTH (SUM_W + SQ_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (a_valid_reg),
        .waddr (a_addr_reg),
        .wdata ({new_sum, new_sq}),
        .re    (in_valid),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (fw_valid_reg && (fw_addr_reg == a_addr_reg))
        begin
            old_sum = fw_sum_reg;
            old_sq  = fw_sq_reg;
        end
        else
        begin
            old_sum = ram_rdata[SUM_W+SQ_W-1:SQ_W];
            old_sq  = ram_rdata[SQ_W-1:0];
        end
        pix_sq = 16'(a_pix_reg) * 16'(a_pix_reg);
        if (a_flags_reg.first)
        begin
            new_sum = SUM_W'(a_pix_reg);
            new_sq  = SQ_W'(pix_sq);
        end
        else
        begin
            new_sum = old_sum + SUM_W'(a_pix_reg);
            new_sq  = old_sq + SQ_W'(pix_sq);
        end
    end

    assign retire = a_valid_reg && !a_flags_reg.last_frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            fw_valid_reg <= 1'b0;
            b_ok_reg     <= 1'b0;
            c_ok_reg     <= 1'b0;
            dv_reg[0]    <= 1'b0;
        end
        else
        begin
            a_valid_reg  <= in_valid;
            fw_valid_reg <= a_valid_reg;
            b_ok_reg     <= a_valid_reg && a_flags_reg.last_frame;
            c_ok_reg     <= b_ok_reg;
            dv_reg[0]    <= c_ok_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_addr_reg  <= in_addr;
        a_pix_reg   <= in_pixel;
        a_flags_reg <= in_flags;
        fw_addr_reg <= a_addr_reg;
        fw_sum_reg  <= new_sum;
        fw_sq_reg   <= new_sq;
        b_sum_reg   <= new_sum;
        b_sq_reg    <= new_sq;
        b_last_reg  <= a_flags_reg.last_pixel;
        c_num_reg   <= NUM_W'(n_eff) * NUM_W'(b_sq_reg);
        c_ss_reg    <= SS_W'(b_sum_reg) * SS_W'(b_sum_reg);
        c_sum_reg   <= b_sum_reg;
        c_last_reg  <= b_last_reg;
        // A single-frame stack divides by one and has no spread.
        if (n_eff == N_W'(1))
        begin
            den_reg <= DEN_W'(1);
        end
        else
        begin
            den_reg <= DEN_W'(n_eff) * DEN_W'(n_eff - N_W'(1));
        end
        if ((n_eff != N_W'(1)) && (CW'(c_num_reg) > CW'(c_ss_reg)))
        begin
            vr_reg[0] <= CW'(c_num_reg) - CW'(c_ss_reg);
        end
        else
        begin
            vr_reg[0] <= '0;
        end
        vq_reg[0] <= '0;
        mr_reg[0] <= MW'(c_sum_reg);
        mq_reg[0] <= '0;
        dl_reg[0] <= c_last_reg;
    end

    // Two restoring dividers side by side, one quotient bit per stage.
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        localparam int SH = QW - 1 - k;
        logic [CW-1:0] v_div;
        logic [MW-1:0] m_div;
        logic          v_ge;
        logic          m_ge;

        assign v_div = CW'(den_reg) << SH;
        assign m_div = MW'(n_eff) << SH;
        assign v_ge  = (vr_reg[k] >= v_div);
        assign m_ge  = (mr_reg[k] >= m_div);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k+1] <= 1'b0;
            end
            else
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            vr_reg[k+1] <= v_ge ? (vr_reg[k] - v_div) : vr_reg[k];
            mr_reg[k+1] <= m_ge ? (mr_reg[k] - m_div) : mr_reg[k];
            vq_reg[k+1] <= {vq_reg[k][QW-2:0], v_ge};
            mq_reg[k+1] <= {mq_reg[k][QW-2:0], m_ge};
            dl_reg[k+1] <= dl_reg[k];
        end
    end

    // Integer square root, two radicand bits per stage.
    for (genvar k = 0; k < RS; k++)
    begin : g_root
        localparam int BP = 2 * (RS - 1 - k);
        logic        ok_in;
        logic        last_in;
        logic [15:0] v_in;
        logic [15:0] r_in;
        logic [7:0]  m_in;
        logic [16:0] trial;

        if (k == 0)
        begin : g_first
            assign ok_in   = dv_reg[QW];
            assign last_in = dl_reg[QW];
            assign v_in    = vq_reg[QW];
            assign r_in    = 16'd0;
            assign m_in    = mq_reg[QW][7:0];
        end
        else
        begin : g_rest
            assign ok_in   = rt_ok_reg[k];
            assign last_in = rt_last_reg[k];
            assign v_in    = rt_v_reg[k];
            assign r_in    = rt_r_reg[k];
            assign m_in    = rt_m_reg[k];
        end

        assign trial = 17'(r_in) + (17'd1 << BP);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rt_ok_reg[k+1] <= 1'b0;
            end
            else
            begin
                rt_ok_reg[k+1] <= ok_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (17'(v_in) >= trial)
            begin
                rt_v_reg[k+1] <= v_in - trial[15:0];
                rt_r_reg[k+1] <= (r_in >> 1) + (16'd1 << BP);
            end
            else
            begin
                rt_v_reg[k+1] <= v_in;
                rt_r_reg[k+1] <= r_in >> 1;
            end
            rt_m_reg[k+1]    <= m_in;
            rt_last_reg[k+1] <= last_in;
        end
    end

    assign out_valid = rt_ok_reg[RS];
    assign out_mean  = rt_m_reg[RS];
    assign out_sigma = rt_r_reg[RS][7:0];
    assign out_last  = rt_last_reg[RS];

endmodule
`default_nettype wire
